>>> hw/rtl/lcar_pkg.sv
// Shared constants and types for the load-cell converter readout.
package lcar_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int AVG_COUNT_BITS = 8;
    localparam int SUM_W          = 32;
    localparam int HALF_W         = 16;
    localparam int GAIN_W         = 2;
    localparam int OFFSET_W       = 24;
    localparam int NET_W          = 25;
    localparam int BIT_W          = $clog2(SAMPLE_BITS + 4);
    localparam int DIV_CNT_W      = $clog2(SUM_W);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_DOWN  = 2'd3;

    typedef struct packed {
        logic                      start;
        logic [SUM_W-1:0]          dividend;
        logic [AVG_COUNT_BITS-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/lcar_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module lcar_div (
    input  logic             clk,
    input  logic             rst_n,
    input  lcar_pkg::div_cmd_t cmd,
    output lcar_pkg::div_rsp_t rsp
);
    import lcar_pkg::*;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]          quo_reg, quo_next;
    logic [AVG_COUNT_BITS-1:0] rem_reg, rem_next;
    logic [AVG_COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [AVG_COUNT_BITS:0]   trial;
    logic [AVG_COUNT_BITS:0]   trial_sub;
    logic                      fits;

    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign fits      = (trial >= {1'b0, dsr_reg});
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(SUM_W - 1);
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? trial_sub[AVG_COUNT_BITS-1:0] : trial[AVG_COUNT_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    // remainder stays below the divisor throughout
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
`endif

endmodule

>>> hw/rtl/load_cell_adc_reader_unit.sv
// Load-cell converter two-wire readout: tick sequencer, averaging and offset handling.
// Each accepted request is one time tick: func, the sampled data line and an offset
// to load. Each tick yields exactly one result: the clock line level, the busy flag,
// and on the closing tick of a run the measurement (average and net) or tare
// notice. A measure or tare request waits for the data line to go low, clocks out
// 24 bits MSB first (sampled at the end of each high phase), adds 0 to 3 gain
// pulses, sums avg_count readings and divides with truncation toward zero. An
// ordinary tick's result is registered in the cycle after acceptance; the tick
// that closes the last reading of a run waits for the bit-serial divider, which
// produces one quotient bit per cycle over the 32-bit sum. A fresh request is taken
// when no division is running and the result register is empty or being taken.
// There is no clearing pass after reset. Configuration writes are taken at any time.
module load_cell_adc_reader_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  wr_en,
    input  logic [lcar_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]       wr_data,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            func,
    input  logic                                  dout,
    input  logic signed [lcar_pkg::OFFSET_W-1:0]  new_offset,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  sck,
    output logic                                  busy_res,
    output logic                                  result_valid,
    output logic signed [lcar_pkg::NET_W-1:0]     net_value,
    output logic signed [lcar_pkg::OFFSET_W-1:0]  average_value,
    output logic                                  tare_done
);
    import lcar_pkg::*;

    // func codes
    localparam logic [1:0] FN_TICK    = 2'd0;
    localparam logic [1:0] FN_MEASURE = 2'd1;
    localparam logic [1:0] FN_TARE    = 2'd2;
    localparam logic [1:0] FN_LOAD    = 2'd3;

    // serial-line phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    // sequencer: take ticks, or wait on the divider
    localparam logic S_TICK = 1'b0;
    localparam logic S_DIV  = 1'b1;

    // configuration registers
    logic [GAIN_W-1:0]         gain_reg;
    logic [AVG_COUNT_BITS-1:0] avgc_reg;
    logic [HALF_W-1:0]         half_reg;
    logic                      pd_reg;

    // line state
    logic [1:0]                phase_reg, phase_next;
    logic [HALF_W-1:0]         tick_reg, tick_next;
    logic [BIT_W-1:0]          bit_reg, bit_next;
    logic [SAMPLE_BITS-1:0]    shift_reg, shift_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [AVG_COUNT_BITS-1:0] rdg_reg, rdg_next;
    logic [OFFSET_W-1:0]       offset_reg, offset_next;
    logic                      tare_reg, tare_next;
    logic                      lvl_reg, lvl_next;
    logic                      seq_reg, seq_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic                      sck_reg, sck_next;
    logic                      busy_out_reg, busy_out_next;
    logic                      res_valid_reg, res_valid_next;
    logic [NET_W-1:0]          net_reg, net_next;
    logic [OFFSET_W-1:0]       avg_reg, avg_next;
    logic                      tdone_reg, tdone_next;

    // step logic
    logic                      accept;
    logic                      finish;
    logic                      span_done;
    logic [BIT_W-1:0]          total_bits;
    logic [AVG_COUNT_BITS-1:0] n_eff;
    logic [SUM_W-1:0]          sum_add;
    logic [AVG_COUNT_BITS-1:0] rdg_inc;
    logic                      div_fin;
    logic [SUM_W-1:0]          avg_full;
    logic [NET_W-1:0]          net_calc;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (seq_reg == S_TICK) && (!out_valid_reg || out_ready);
    assign span_done  = ({1'b0, tick_reg} + (HALF_W+1)'(1)) >= {1'b0, half_reg};
    assign total_bits = BIT_W'(SAMPLE_BITS) + BIT_W'(gain_reg);
    assign n_eff      = (avgc_reg == '0) ? AVG_COUNT_BITS'(1) : avgc_reg;
    assign sum_add    = sum_reg + {{(SUM_W-SAMPLE_BITS){shift_reg[SAMPLE_BITS-1]}}, shift_reg};
    assign rdg_inc    = rdg_reg + 1'b1;

    // closing division: sum_reg already holds the final sum while the divider runs
    assign div_fin  = (seq_reg == S_DIV) && div_rsp.done;
    assign avg_full = sum_reg[SUM_W-1] ? (SUM_W'(0) - div_rsp.quotient) : div_rsp.quotient;
    assign net_calc = avg_full[NET_W-1:0] - {offset_reg[OFFSET_W-1], offset_reg};

    assign div_cmd.start    = accept && finish;
    assign div_cmd.dividend = sum_add[SUM_W-1] ? (SUM_W'(0) - sum_add) : sum_add;
    assign div_cmd.divisor  = n_eff;

    lcar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // one tick of the line sequencer
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        sum_next    = sum_reg;
        rdg_next    = rdg_reg;
        offset_next = offset_reg;
        tare_next   = tare_reg;
        lvl_next    = lvl_reg;
        finish      = 1'b0;

        if (pd_reg)
        begin
            // power-down drops any run
            phase_next = PH_IDLE;
            lvl_next   = 1'b0;
            tick_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    case (func) inside
                        FN_MEASURE, FN_TARE:
                        begin
                            tare_next  = (func == FN_TARE);
                            sum_next   = '0;
                            rdg_next   = '0;
                            phase_next = PH_WAIT;
                        end
                        FN_LOAD:
                            offset_next = new_offset;
                        FN_TICK:
                            offset_next = offset_reg;
                        default:
                            offset_next = offset_reg;
                    endcase
                end
                PH_WAIT:
                begin
                    if (!dout)
                    begin
                        lvl_next   = 1'b1;
                        tick_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    if (span_done)
                    begin
                        // sample at the end of the high phase
                        if (bit_reg < BIT_W'(SAMPLE_BITS))
                            shift_next = {shift_reg[SAMPLE_BITS-2:0], dout};
                        bit_next   = bit_reg + 1'b1;
                        lvl_next   = 1'b0;
                        tick_next  = '0;
                        phase_next = PH_LOW;
                    end
                    else
                        tick_next = tick_reg + 1'b1;
                end
                PH_LOW:
                begin
                    if (!span_done)
                        tick_next = tick_reg + 1'b1;
                    else if (bit_reg < total_bits)
                    begin
                        lvl_next   = 1'b1;
                        tick_next  = '0;
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        tick_next = '0;
                        sum_next  = sum_add;
                        rdg_next  = rdg_inc;
                        if (rdg_inc >= n_eff)
                        begin
                            finish     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                            phase_next = PH_WAIT;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // result register and sequencer
    always_comb
    begin
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sck_next       = sck_reg;
        busy_out_next  = busy_out_reg;
        res_valid_next = res_valid_reg;
        net_next       = net_reg;
        avg_next       = avg_reg;
        tdone_next     = tdone_reg;

        unique case (seq_reg)
            S_TICK:
            begin
                if (accept && finish)
                    seq_next = S_DIV;
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    sck_next       = pd_reg | lvl_next;
                    busy_out_next  = (phase_next != PH_IDLE);
                    res_valid_next = 1'b0;
                    net_next       = '0;
                    avg_next       = '0;
                    tdone_next     = 1'b0;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    seq_next       = S_TICK;
                    out_valid_next = 1'b1;
                    sck_next       = lvl_reg;
                    busy_out_next  = 1'b0;
                    res_valid_next = !tare_reg;
                    net_next       = tare_reg ? '0 : net_calc;
                    avg_next       = avg_full[OFFSET_W-1:0];
                    tdone_next     = tare_reg;
                end
            end
            default:
                seq_next = S_TICK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_W'(1);
            avgc_reg      <= AVG_COUNT_BITS'(1);
            half_reg      <= HALF_W'(1);
            pd_reg        <= 1'b0;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            rdg_reg       <= '0;
            offset_reg    <= '0;
            tare_reg      <= 1'b0;
            lvl_reg       <= 1'b0;
            seq_reg       <= S_TICK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_GAIN_PULSES: gain_reg <= wr_data[GAIN_W-1:0];
                    REG_AVG_COUNT:   avgc_reg <= wr_data[AVG_COUNT_BITS-1:0];
                    REG_HALF_PERIOD: half_reg <= wr_data[HALF_W-1:0];
                    REG_POWER_DOWN:  pd_reg   <= wr_data[0];
                    default:         pd_reg   <= pd_reg;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                sum_reg   <= sum_next;
                rdg_reg   <= rdg_next;
                tare_reg  <= tare_next;
                lvl_reg   <= lvl_next;
            end
            // tare writes the offset when the division lands
            if (accept)
                offset_reg <= offset_next;
            else if (div_fin && tare_reg)
                offset_reg <= avg_full[OFFSET_W-1:0];
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sck_reg       <= sck_next;
        busy_out_reg  <= busy_out_next;
        res_valid_reg <= res_valid_next;
        net_reg       <= net_next;
        avg_reg       <= avg_next;
        tdone_reg     <= tdone_next;
    end

    assign out_valid     = out_valid_reg;
    assign sck           = sck_reg;
    assign busy_res      = busy_out_reg;
    assign result_valid  = res_valid_reg;
    assign net_value     = net_reg;
    assign average_value = avg_reg;
    assign tare_done     = tdone_reg;

`ifndef SYNTHESIS
    // no request is taken while the divider is still working
    a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_rsp.busy)
        else $error("request taken while divider busy");
    // a finished division always lands in the result register
    a_div_lands: assert property (@(posedge clk) disable iff (!rst_n)
        div_fin |=> out_valid_reg)
        else $error("division result not presented");
    // measurement and tare never report together
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_valid_reg && tdone_reg))
        else $error("result and tare flagged together");
    // bit counter never passes data plus the largest gain train
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_W'(SAMPLE_BITS + 3))
        else $error("bit counter out of range");
`endif

endmodule
